// File: sv/pcg_pkg.sv
// Package for the periodic chirp generator: widths, CORDIC constants, register indexes.
// Used by pcg_divider and periodic_chirp_generator.
`timescale 1ns / 1ps
package pcg_pkg;

  localparam int DEF_MAX_LENGTH  = 65536;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int LEN_W    = 17;
  localparam int RATE_W   = 16;
  localparam int IDX_W    = 16;
  localparam int OUT_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE   = 1'd1;

  localparam int TURN_W  = 24;
  localparam int STAGES  = 20;
  localparam int CW      = 34;
  localparam int ZW      = 34;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] r;
    r = '0;
    unique case (i)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW:0] r;
    r = (CW+1)'(v + 34'sd16384) >>> 15;
    if (r > 35'sd32767) return 16'sh7fff;
    if (r < -35'sd32768) return 16'sh8000;
    return r[OUT_W-1:0];
  endfunction

endpackage

// File: sv/pcg_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with stall.
// Uses pcg_pkg; instantiated by periodic_chirp_generator.
`timescale 1ns / 1ps
module pcg_divider #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 26,
  parameter int Q_W   = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             out_valid,
  output logic [Q_W-1:0]   quot
);
  import pcg_pkg::*;

  logic               vld  [Q_W+1];
  logic [DEN_W:0]     rem  [Q_W];
  logic [NUM_W-1:0]   nm   [Q_W];
  logic [DEN_W-1:0]   dn   [Q_W];
  logic [Q_W-1:0]     qt   [Q_W+1];

  assign vld[0] = in_valid;
  assign rem[0] = {1'b0, num[NUM_W-1 -: DEN_W]};
  assign nm[0]  = num;
  assign dn[0]  = den;
  assign qt[0]  = '0;

  // low Q_W quotient bits only; numerator high part must already be below den
  for (genvar s = 0; s < Q_W; s++) begin : g_st
    logic [DEN_W+1:0] sh;
    logic [DEN_W+1:0] df;
    logic             ge;
    always_comb begin
      sh = {rem[s], nm[s][NUM_W-1-DEN_W-s]};
      df = sh - {2'b0, dn[s]};
      ge = !df[DEN_W+1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        qt[s+1] <= {qt[s][Q_W-2:0], ge};
      end
    end
    if (s < Q_W-1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= ge ? df[DEN_W:0] : sh[DEN_W:0];
          nm[s+1]  <= nm[s];
          dn[s+1]  <= dn[s];
        end
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quot      = qt[Q_W];
endmodule

// File: sv/periodic_chirp_generator.sv
// Periodic chirp generator top level: modular phase, divider, CORDIC, Q1.15 output.
// Uses pcg_pkg and pcg_divider.
//
// Usage: write chirp_length (index 0) and chirp_rate (index 1) through cfg_we,
// cfg_index and cfg_data while idle. Send sample indexes on in_valid/in_stall
// with sample_index; each beat gives one beat on out_valid/out_stall carrying
// cos_value and sin_value, cos(pi*k/L) and sin(pi*k/L) in Q1.15.
// Throughput: one beat per cycle unless out_stall holds the output. Stages: 2 multiply,
// 2*SB+16 modulo-2L (SB is SAMPLE_BITS capped at 16; 48 by default), one phase fold,
// 24 divider, 20 CORDIC and one output stage.
// The whole pipeline advances together when the output register is empty or
// taken; in_stall is high exactly when the output holds a beat that is stalled,
// so a stall loses and repeats nothing.
// Reset clears all valid bits and sets length 1024, rate 1.
`timescale 1ns / 1ps
module periodic_chirp_generator #(
  parameter int MAX_LENGTH  = pcg_pkg::DEF_MAX_LENGTH,
  parameter int SAMPLE_BITS = pcg_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcg_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pcg_pkg::IDX_W-1:0]         sample_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pcg_pkg::OUT_W-1:0]  cos_value,
  output logic signed [pcg_pkg::OUT_W-1:0]  sin_value
);
  import pcg_pkg::*;

  localparam int ML_W  = $clog2(MAX_LENGTH + 1);
  localparam int LL_W  = (ML_W > LEN_W) ? ML_W : LEN_W;
  localparam int TL_W  = LL_W + 1;
  localparam int SB    = (SAMPLE_BITS < IDX_W) ? SAMPLE_BITS : IDX_W;
  localparam int NUM_W = TL_W + TURN_W;
  localparam int XW    = 2*SB + RATE_W;

  logic [LEN_W-1:0]  chirp_length;
  logic [RATE_W-1:0] chirp_rate;
  logic              en;

  always_ff @(posedge clk) begin
    if (rst) begin
      chirp_length <= LEN_W'(1024);
      chirp_rate   <= RATE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LENGTH: chirp_length <= cfg_data[LEN_W-1:0];
        REG_RATE:   chirp_rate   <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LL_W-1:0] len;
  logic [TL_W-1:0] two_len;
  always_comb begin
    len = LL_W'(chirp_length);
    if (chirp_length == '0) len = LL_W'(1);
    if ({1'b0, len} > (LL_W+1)'(MAX_LENGTH)) len = LL_W'(MAX_LENGTH);
    two_len = {len, 1'b0};
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // square the index, then scale by the rate
  logic            v1, v2;
  logic [2*SB-1:0] sq1;
  logic [XW-1:0]   x2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1 <= (2*SB)'(sample_index[SB-1:0]) * (2*SB)'(sample_index[SB-1:0]);
      x2  <= XW'(sq1) * XW'(chirp_rate);
    end
  end

  // reduce n*m*m modulo 2L, one bit per stage
  logic            rv [XW+1];
  logic [XW-1:0]   rx [XW];
  logic [TL_W-1:0] rr [XW+1];
  assign rv[0] = v2; assign rx[0] = x2; assign rr[0] = '0;

  for (genvar j = 0; j < XW; j++) begin : g_mod
    logic [TL_W:0]   sh;
    logic [TL_W+1:0] df;
    always_comb begin
      sh = {rr[j], rx[j][XW-1-j]};
      df = {1'b0, sh} - {2'b0, two_len};
    end
    always_ff @(posedge clk) begin
      if (rst) rv[j+1] <= 1'b0;
      else if (en) rv[j+1] <= rv[j];
      if (en) rr[j+1] <= df[TL_W+1] ? sh[TL_W-1:0] : df[TL_W-1:0];
    end
    if (j < XW-1) begin : g_x
      always_ff @(posedge clk) begin
        if (en) rx[j+1] <= rx[j];
      end
    end
  end

  // (L+1)*X mod 2L: add L when X is odd, fold once
  logic            vk;
  logic [TL_W-1:0] k;
  logic [TL_W:0]   ks;
  always_comb begin
    ks = {1'b0, rr[XW]};
    if (rr[XW][0]) ks = ks + (TL_W+1)'(len);
    if (ks >= {1'b0, two_len}) ks = ks - {1'b0, two_len};
  end

  always_ff @(posedge clk) begin
    if (rst) vk <= 1'b0;
    else if (en) vk <= rv[XW];
    if (en) k <= ks[TL_W-1:0];
  end

  logic               dv;
  logic [TURN_W-1:0]  turn;
  pcg_divider #(.NUM_W(NUM_W), .DEN_W(TL_W), .Q_W(TURN_W)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(vk),
    .num(({k, {TURN_W{1'b0}}}) + NUM_W'(len)),
    .den(two_len), .out_valid(dv), .quot(turn)
  );

  logic [1:0]            q0;
  logic signed [ZW-1:0]  z0;
  logic [31:0]           ang, rem0;
  always_comb begin
    ang  = {turn, 8'd0};
    q0   = 2'((ang + 32'h2000_0000) >> 30);
    rem0 = ang - {q0, 30'd0};
    z0   = ZW'($signed(rem0));
  end

  logic                 cv [STAGES+1];
  logic signed [CW-1:0] cx [STAGES+1];
  logic signed [CW-1:0] cy [STAGES+1];
  logic signed [ZW-1:0] cz [STAGES+1];
  logic [1:0]           cq [STAGES+1];
  assign cv[0] = dv; assign cx[0] = GAIN_Q30; assign cy[0] = '0;
  assign cz[0] = z0; assign cq[0] = q0;

  for (genvar i = 0; i < STAGES; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (en) cv[i+1] <= cv[i];
      if (en) begin
        cq[i+1] <= cq[i];
        if (!cz[i][ZW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_turn(i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_turn(i);
        end
      end
    end
  end

  logic signed [CW-1:0] fc, fs, fx, fy;
  always_comb begin
    fx = cx[STAGES]; fy = cy[STAGES];
    unique case (cq[STAGES])
      2'd1:    begin fc = -fy; fs = fx;  end
      2'd2:    begin fc = -fx; fs = -fy; end
      2'd3:    begin fc = fy;  fs = -fx; end
      default: begin fc = fx;  fs = fy;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= cv[STAGES];
    if (en) begin
      cos_value <= to_q15(fc);
      sin_value <= to_q15(fs);
    end
  end
endmodule

// File: sim/tb.sv
// Testbench for periodic_chirp_generator: directed and random sample indexes
// under random idling, checked against an in-bench chirp and CORDIC predictor.
// Depends on pcg_pkg and the periodic_chirp_generator RTL.
`timescale 1ns / 1ps
module tb;
  import pcg_pkg::*;

  localparam int LATENCY = 96;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint GAIN = 652032874;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [IDX_W-1:0] sample_index;
  logic out_valid;
  logic out_stall;
  logic signed [OUT_W-1:0] cos_value;
  logic signed [OUT_W-1:0] sin_value;

  logic [LEN_W-1:0] cur_length;
  logic [RATE_W-1:0] cur_rate;
  logic signed [OUT_W-1:0] cos_expected[$];
  logic signed [OUT_W-1:0] sin_expected[$];
  int errors;
  int idle_pct;
  longint cycles;
  longint phase_turns[STAGES];

  periodic_chirp_generator DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample_index(sample_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .cos_value(cos_value), .sin_value(sin_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    phase_turns = '{536870912, 316933406, 167458907, 85004756, 42667331,
                    21354465, 10679838, 5340245, 2670163, 1335087,
                    667544, 333772, 166886, 83443, 41722,
                    20861, 10430, 5215, 2608, 1304};
  end

  function automatic logic signed [OUT_W-1:0] round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[OUT_W-1:0];
  endfunction

  task automatic chirp_sample(input logic [IDX_W-1:0] m_in,
                              output logic signed [OUT_W-1:0] c_out,
                              output logic signed [OUT_W-1:0] s_out);
    longint len, two_len, m, k, t, angle, q, rem, x, y, z, dx, dy, c, s;
    len = cur_length;
    if (len == 0) len = 1;
    if (len > 65536) len = 65536;
    two_len = 2 * len;
    m = m_in % two_len;
    k = (len + 1) % two_len;
    k = (k * (cur_rate % two_len)) % two_len;
    k = (k * m) % two_len;
    k = (k * m) % two_len;
    t = ((k << 24) + len) / two_len;
    t = t & 64'hFFFFFF;
    angle = t << 8;
    q = ((angle + (64'd1 << 29)) >> 30) & 3;
    rem = (angle - (q << 30)) & 64'hFFFFFFFF;
    z = (rem >= 64'h80000000) ? rem - 64'h100000000 : rem;
    x = GAIN;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= phase_turns[i];
      end else begin
        x += dx; y -= dy; z += phase_turns[i];
      end
    end
    case (q)
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      3: begin c = y; s = -x; end
      default: begin c = x; s = y; end
    endcase
    c_out = round_q15(c);
    s_out = round_q15(s);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver side stall
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (cos_expected.size() == 0) begin
        $display("%0t: unexpected beat cos=%0d sin=%0d", $time, cos_value, sin_value);
        errors++;
      end else begin
        if (cos_value !== cos_expected[0]) begin
          $display("%0t: cos_value expected %0d actual %0d", $time, cos_expected[0], cos_value);
          errors++;
        end
        if (sin_value !== sin_expected[0]) begin
          $display("%0t: sin_value expected %0d actual %0d", $time, sin_expected[0], sin_value);
          errors++;
        end
        void'(cos_expected.pop_front());
        void'(sin_expected.pop_front());
      end
    end
  end

  task automatic send_index(input logic [IDX_W-1:0] m);
    logic signed [OUT_W-1:0] c, s;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample_index = m;
    do @(posedge clk); while (in_stall);
    chirp_sample(m, c, s);
    cos_expected.push_back(c);
    sin_expected.push_back(s);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (cos_expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_LENGTH) cur_length = data;
    else cur_rate = data[RATE_W-1:0];
  endtask

  task automatic test_reset_defaults();
    send_index(16'd0);
    send_index(16'd1);
    send_index(16'd1023);
    send_index(16'd1024);
    send_index(16'hFFFF);
    send_index(16'h5555);
    send_index(16'hAAAA);
  endtask

  task automatic test_length_extremes();
    write_reg(REG_LENGTH, 17'd0);
    send_index(16'd3);
    send_index(16'hFFFF);
    write_reg(REG_LENGTH, 17'd1);
    send_index(16'd7);
    write_reg(REG_LENGTH, 17'd65536);
    write_reg(REG_RATE, 17'd65535);
    send_index(16'hFFFF);
    send_index(16'd12345);
    write_reg(REG_LENGTH, 17'h1FFFF);
    send_index(16'hFFFF);
    send_index(16'd40000);
  endtask

  task automatic test_rate_extremes();
    write_reg(REG_LENGTH, 17'd100);
    write_reg(REG_RATE, 17'd0);
    send_index(16'd55);
    write_reg(REG_RATE, 17'h1FFFF);
    send_index(16'd55);
    send_index(16'd250);
    write_reg(REG_RATE, 17'h10003);
    send_index(16'd199);
    send_index(16'd200);
  endtask

  task automatic test_random_phases();
    logic [CFG_DAT_W-1:0] len;
    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(3))
        0: len = CFG_DAT_W'($urandom_range(16, 1));
        1: len = CFG_DAT_W'($urandom_range(65536, 1));
        2: len = CFG_DAT_W'($urandom_range(131071, 65536));
        default: len = CFG_DAT_W'($urandom_range(2000, 1));
      endcase
      write_reg(REG_LENGTH, len);
      write_reg(REG_RATE, CFG_DAT_W'($urandom_range(131071)));
      idle_pct = (p == 5) ? 0 : 31;
      for (int i = 0; i < 38; i++) send_index(IDX_W'($urandom_range(65535)));
    end
    idle_pct = 31;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_LENGTH;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_index = '0;
    errors = 0;
    cycles = 0;
    idle_pct = 31;
    cur_length = 17'd1024;
    cur_rate = 16'd1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_length_extremes();
    test_rate_extremes();
    test_random_phases();
    drain();
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0 && cos_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
